// ----- rtl/core/dma_slot_batch_sequencer_defines.svh -----
// ----------------------------------------------------------------------------
// dma_slot_batch_sequencer_defines
// Assertion macros shared by the checker of the slot batch sequencer.
// ----------------------------------------------------------------------------
`ifndef DMA_SLOT_BATCH_SEQUENCER_DEFINES_SVH
`define DMA_SLOT_BATCH_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define DSBS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define DSBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/dsbs_pkg.sv -----
// ----------------------------------------------------------------------------
// dsbs_pkg
// Types, codes and reset values of the DMA slot batch sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dsbs_pkg;

   // Default size of the slot pool
   localparam int unsigned SLOT_COUNT_DEF = 2;

   // Request commands
   typedef enum logic [1:0] {
      CMD_IRQ     = 2'd0,
      CMD_DONE    = 2'd1,
      CMD_ERROR   = 2'd2,
      CMD_PROCESS = 2'd3
   } cmd_type;

   // Slot life cycle
   typedef enum logic [1:0] {
      SLOT_FREE   = 2'd0,
      SLOT_ACTIVE = 2'd1,
      SLOT_READY  = 2'd2
   } slot_state_type;

   // Outcome of a process request
   typedef enum logic [1:0] {
      PR_NONE      = 2'd0,
      PR_PUBLISHED = 2'd1,
      PR_DROPPED   = 2'd2
   } proc_result_type;

   // Register indexes of the configuration port
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MID_OFFSET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOMINAL    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DT_MIN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DT_MAX     = 3'd4;

   // Fault flag masks
   localparam logic [5:0] FAULT_IRQ_BUSY = 6'b00_0001;
   localparam logic [5:0] FAULT_NO_SLOT  = 6'b00_0010;
   localparam logic [5:0] FAULT_START    = 6'b00_0100;
   localparam logic [5:0] FAULT_XFER     = 6'b00_1000;
   localparam logic [5:0] FAULT_PARSE    = 6'b01_0000;
   localparam logic [5:0] FAULT_BAD_DT   = 6'b10_0000;

   // Configuration reset values
   localparam logic [15:0] NOMINAL_RST = 16'd1000;
   localparam logic [31:0] DT_MIN_RST  = 32'd500;
   localparam logic [31:0] DT_MAX_RST  = 32'd2000;

   typedef struct packed {
      logic        enable;
      logic [15:0] midpoint_offset_us;
      logic [15:0] nominal_period_us;
      logic [31:0] dt_min_us;
      logic [31:0] dt_max_us;
   } cfg_type;

   typedef struct packed {
      cmd_type     command;
      logic [31:0] now_us;
      logic        start_ok;
      logic        decode_ok;
   } req_type;

   typedef struct packed {
      logic            accepted;
      proc_result_type process_result;
      logic            slot_index;
      logic [31:0]     irq_time_us;
      logic [31:0]     sample_time_us;
      logic [31:0]     interval_us;
      logic [31:0]     sequence_res;
      logic [5:0]      fault_bits;
      logic            healthy;
      logic [31:0]     min_interval_us;
      logic [31:0]     max_interval_us;
   } rsp_type;

endpackage

`default_nettype wire

// ----- rtl/core/dma_slot_batch_sequencer.sv -----
// One request is taken per clock cycle while the result side does not stall. A
// request sits in the input register while the event logic works it against the
// slot pool, and its result lands in the result register when that register is
// free or being emptied; the result is then offered until it is taken.
// The pass from input register to result register is a single one, with every
// slot searched in parallel; a stalled result holds the input register and then
// the request side.
// ----------------------------------------------------------------------------
// dma_slot_batch_sequencer
// Transfer slot pool manager: claims, completes, frees and publishes batches.
// ----------------------------------------------------------------------------
`default_nettype none

module dma_slot_batch_sequencer
   import dsbs_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_command,
   input  logic [31:0]            req_now_us,
   input  logic                   req_start_ok,
   input  logic                   req_decode_ok,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_accepted,
   output logic [1:0]             rsp_process_result,
   output logic                   rsp_slot_index,
   output logic [31:0]            rsp_irq_time_us,
   output logic [31:0]            rsp_sample_time_us,
   output logic [31:0]            rsp_interval_us,
   output logic [31:0]            rsp_sequence_res,
   output logic [5:0]             rsp_fault_bits,
   output logic                   rsp_healthy,
   output logic [31:0]            rsp_min_interval_us,
   output logic [31:0]            rsp_max_interval_us,
   // configuration port
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_next;
   logic    fire, req_take;

   // Work the held request when the result register is free or being emptied
   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ENABLE:     cfg_in.enable             = csr_wdata[0];
            CSR_MID_OFFSET: cfg_in.midpoint_offset_us = csr_wdata[15:0];
            CSR_NOMINAL:    cfg_in.nominal_period_us  = csr_wdata[15:0];
            CSR_DT_MIN:     cfg_in.dt_min_us          = csr_wdata;
            CSR_DT_MAX:     cfg_in.dt_max_us          = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable             <= 1'b0;
         cfg_ff.midpoint_offset_us <= '0;
         cfg_ff.nominal_period_us  <= NOMINAL_RST;
         cfg_ff.dt_min_us          <= DT_MIN_RST;
         cfg_ff.dt_max_us          <= DT_MAX_RST;
         in_valid_ff               <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Input and result payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff.command   <= cmd_type'(req_command);
         in_ff.now_us    <= req_now_us;
         in_ff.start_ok  <= req_start_ok;
         in_ff.decode_ok <= req_decode_ok;
      end
      if (fire) begin
         rsp_ff <= rsp_next;
      end
   end

   dsbs_core #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (in_ff),
      .cfg   (cfg_ff),
      .rsp   (rsp_next)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = rsp_ff.accepted;
   assign rsp_process_result  = rsp_ff.process_result;
   assign rsp_slot_index      = rsp_ff.slot_index;
   assign rsp_irq_time_us     = rsp_ff.irq_time_us;
   assign rsp_sample_time_us  = rsp_ff.sample_time_us;
   assign rsp_interval_us     = rsp_ff.interval_us;
   assign rsp_sequence_res    = rsp_ff.sequence_res;
   assign rsp_fault_bits      = rsp_ff.fault_bits;
   assign rsp_healthy         = rsp_ff.healthy;
   assign rsp_min_interval_us = rsp_ff.min_interval_us;
   assign rsp_max_interval_us = rsp_ff.max_interval_us;

endmodule

`default_nettype wire

// ----- rtl/core/dsbs_slot_pick.sv -----
// ----------------------------------------------------------------------------
// dsbs_slot_pick
// Finds the lowest free slot and the oldest ready slot of the pool.
// ----------------------------------------------------------------------------
`default_nettype none

module dsbs_slot_pick
   import dsbs_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  slot_state_type                                  status [SLOT_COUNT],
   input  logic [31:0]                                     order  [SLOT_COUNT],
   output logic                                            free_found,
   output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] free_idx,
   output logic                                            ready_found,
   output logic [((SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1)-1:0] ready_idx
);

   localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   logic        older_mat [SLOT_COUNT][SLOT_COUNT];
   logic [31:0] order_diff;

   // Wrap-safe age compare of every pair, all in parallel
   always_comb begin
      order_diff = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         for (int j = 0; j < SLOT_COUNT; j++) begin
            order_diff      = order[i] - order[j];
            older_mat[i][j] = order_diff[31];
         end
      end
   end

   // Priority encode the lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (status[i] == SLOT_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // Walk the ready slots in index order; a later slot wins only if strictly older
   always_comb begin
      ready_found = 1'b0;
      ready_idx   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (status[i] == SLOT_READY && (!ready_found || older_mat[i][ready_idx])) begin
            ready_found = 1'b1;
            ready_idx   = SLOT_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dsbs_core.sv -----
// ----------------------------------------------------------------------------
// dsbs_core
// Slot pool state and the event logic that works one request in one pass.
// ----------------------------------------------------------------------------
`default_nettype none

module dsbs_core
   import dsbs_pkg::*;
#(
   parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Slot pool
   slot_state_type status_ff [SLOT_COUNT];
   slot_state_type status_in [SLOT_COUNT];
   logic [31:0]    irq_time_ff [SLOT_COUNT];
   logic [31:0]    order_ff    [SLOT_COUNT];

   // Sequencing state
   logic              filling_valid_ff, filling_valid_in;
   logic [SLOT_W-1:0] filling_slot_ff, filling_slot_in;
   logic [31:0]       order_cnt_ff, order_cnt_in;
   logic [5:0]        faults_ff, faults_in;
   logic              prev_valid_ff, prev_valid_in;
   logic [31:0]       prev_time_ff, prev_time_in;
   logic [31:0]       seq_ff, seq_in;
   logic [31:0]       min_dt_ff, min_dt_in;
   logic [31:0]       max_dt_ff, max_dt_in;

   // Slot store write controls
   logic              irq_we;
   logic [SLOT_W-1:0] irq_wsel;
   logic              order_we;

   // Search results and datapath
   logic              free_found, ready_found;
   logic [SLOT_W-1:0] free_idx, ready_idx;
   logic [31:0]       irq_rd, ts, dt_meas, dt;
   logic              dt_bad, dt_ok;

   dsbs_slot_pick #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_pick (
      .status      (status_ff),
      .order       (order_ff),
      .free_found  (free_found),
      .free_idx    (free_idx),
      .ready_found (ready_found),
      .ready_idx   (ready_idx)
   );

   // Sample time and measured interval of the oldest ready slot
   assign irq_rd  = irq_time_ff[ready_idx];
   assign ts      = irq_rd - {16'd0, cfg.midpoint_offset_us};
   assign dt_meas = ts - prev_time_ff;
   assign dt_bad  = (dt_meas < cfg.dt_min_us) || (dt_meas > cfg.dt_max_us);
   assign dt      = prev_valid_ff ? dt_meas : {16'd0, cfg.nominal_period_us};
   assign dt_ok   = !prev_valid_ff || !dt_bad;

   // Next state and result of the request in the input register
   always_comb begin
      status_in        = status_ff;
      filling_valid_in = filling_valid_ff;
      filling_slot_in  = filling_slot_ff;
      order_cnt_in     = order_cnt_ff;
      faults_in        = faults_ff;
      prev_valid_in    = prev_valid_ff;
      prev_time_in     = prev_time_ff;
      seq_in           = seq_ff;
      min_dt_in        = min_dt_ff;
      max_dt_in        = max_dt_ff;
      irq_we           = 1'b0;
      irq_wsel         = free_idx;
      order_we         = 1'b0;
      rsp              = '0;

      if (fire && cfg.enable) begin
         case (req.command)
            CMD_IRQ: begin
               if (filling_valid_ff) begin
                  faults_in = faults_ff | FAULT_IRQ_BUSY;
               end else if (!free_found) begin
                  faults_in = faults_ff | FAULT_NO_SLOT;
               end else begin
                  rsp.slot_index = free_idx[0];
                  irq_we         = 1'b1;
                  if (req.start_ok) begin
                     status_in[free_idx] = SLOT_ACTIVE;
                     filling_valid_in    = 1'b1;
                     filling_slot_in     = free_idx;
                     rsp.accepted        = 1'b1;
                  end else begin
                     // start failed: slot stays free
                     status_in[free_idx] = SLOT_FREE;
                     filling_valid_in    = 1'b0;
                     faults_in           = faults_ff | FAULT_START;
                  end
               end
            end
            CMD_DONE: begin
               if (filling_valid_ff) begin
                  order_we                   = 1'b1;
                  order_cnt_in               = order_cnt_ff + 32'd1;
                  status_in[filling_slot_ff] = SLOT_READY;
                  rsp.slot_index             = filling_slot_ff[0];
                  rsp.accepted               = 1'b1;
               end
               filling_valid_in = 1'b0;
            end
            CMD_ERROR: begin
               if (filling_valid_ff) begin
                  status_in[filling_slot_ff] = SLOT_FREE;
                  rsp.slot_index             = filling_slot_ff[0];
               end
               filling_valid_in = 1'b0;
               faults_in        = faults_ff | FAULT_XFER;
               rsp.accepted     = 1'b1;
            end
            CMD_PROCESS: begin
               if (ready_found) begin
                  status_in[ready_idx] = SLOT_FREE;
                  rsp.slot_index       = ready_idx[0];
                  rsp.irq_time_us      = irq_rd;
                  if (!req.decode_ok) begin
                     faults_in          = faults_ff | FAULT_PARSE;
                     rsp.process_result = PR_DROPPED;
                  end else begin
                     // publish: report pending faults, then clear them
                     rsp.fault_bits      = dt_ok ? faults_ff : (faults_ff | FAULT_BAD_DT);
                     faults_in           = '0;
                     prev_valid_in       = 1'b1;
                     prev_time_in        = ts;
                     seq_in              = seq_ff + 32'd1;
                     min_dt_in           = (min_dt_ff == 32'd0 || min_dt_ff > dt) ?
                                           dt : min_dt_ff;
                     max_dt_in           = (max_dt_ff < dt) ? dt : max_dt_ff;
                     rsp.accepted        = 1'b1;
                     rsp.process_result  = PR_PUBLISHED;
                     rsp.sample_time_us  = ts;
                     rsp.interval_us     = dt;
                     rsp.sequence_res    = seq_in;
                     rsp.healthy         = dt_ok && (rsp.fault_bits == 6'd0);
                     rsp.min_interval_us = min_dt_in;
                     rsp.max_interval_us = max_dt_in;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            status_ff[i] <= SLOT_FREE;
         end
         filling_valid_ff <= 1'b0;
         filling_slot_ff  <= '0;
         order_cnt_ff     <= '0;
         faults_ff        <= '0;
         prev_valid_ff    <= 1'b0;
         prev_time_ff     <= '0;
         seq_ff           <= '0;
         min_dt_ff        <= '0;
         max_dt_ff        <= '0;
      end else begin
         status_ff        <= status_in;
         filling_valid_ff <= filling_valid_in;
         filling_slot_ff  <= filling_slot_in;
         order_cnt_ff     <= order_cnt_in;
         faults_ff        <= faults_in;
         prev_valid_ff    <= prev_valid_in;
         prev_time_ff     <= prev_time_in;
         seq_ff           <= seq_in;
         min_dt_ff        <= min_dt_in;
         max_dt_ff        <= max_dt_in;
      end
   end

   // Slot timestamps and completion numbers, written before being read
   always_ff @(posedge clock) begin
      if (irq_we) begin
         irq_time_ff[irq_wsel] <= req.now_us;
      end
      if (order_we) begin
         order_ff[filling_slot_ff] <= order_cnt_ff;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/dsbs_checker.sv -----
// ----------------------------------------------------------------------------
// dsbs_checker
// Port-level checks of the slot batch sequencer results over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dma_slot_batch_sequencer_defines.svh"

module dsbs_checker
   import dsbs_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_accepted,
   input wire logic [1:0]  rsp_process_result,
   input wire logic        rsp_slot_index,
   input wire logic [31:0] rsp_irq_time_us,
   input wire logic [31:0] rsp_sample_time_us,
   input wire logic [31:0] rsp_interval_us,
   input wire logic [31:0] rsp_sequence_res,
   input wire logic [5:0]  rsp_fault_bits,
   input wire logic        rsp_healthy,
   input wire logic [31:0] rsp_min_interval_us,
   input wire logic [31:0] rsp_max_interval_us
);

   // Hold a stalled result
   `DSBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_accepted) && $stable(rsp_process_result) &&
      $stable(rsp_slot_index) && $stable(rsp_irq_time_us) &&
      $stable(rsp_sample_time_us) && $stable(rsp_interval_us) &&
      $stable(rsp_sequence_res) && $stable(rsp_fault_bits) && $stable(rsp_healthy) &&
      $stable(rsp_min_interval_us) && $stable(rsp_max_interval_us),
      "result changed while stalled")

   // A dropped batch is never accepted and publishes no sample
   `DSBS_ASSERT_NOW(a_drop_quiet, rsp_valid && rsp_process_result == PR_DROPPED,
      !rsp_accepted && rsp_sequence_res == 32'd0 && !rsp_healthy,
      "dropped batch carries a sample")

   // Healthy only on a published sample with no faults
   `DSBS_ASSERT_NOW(a_healthy_clean, rsp_valid && rsp_healthy,
      rsp_accepted && rsp_process_result == PR_PUBLISHED && rsp_fault_bits == 6'd0,
      "healthy with faults pending")

   // Running interval bounds stay ordered on every published sample
   `DSBS_ASSERT_NOW(a_bounds_order, rsp_valid && rsp_process_result == PR_PUBLISHED,
      rsp_min_interval_us <= rsp_max_interval_us, "interval bounds out of order")

endmodule

bind dma_slot_batch_sequencer dsbs_checker u_dsbs_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_accepted        (rsp_accepted),
   .rsp_process_result  (rsp_process_result),
   .rsp_slot_index      (rsp_slot_index),
   .rsp_irq_time_us     (rsp_irq_time_us),
   .rsp_sample_time_us  (rsp_sample_time_us),
   .rsp_interval_us     (rsp_interval_us),
   .rsp_sequence_res    (rsp_sequence_res),
   .rsp_fault_bits      (rsp_fault_bits),
   .rsp_healthy         (rsp_healthy),
   .rsp_min_interval_us (rsp_min_interval_us),
   .rsp_max_interval_us (rsp_max_interval_us)
);

`default_nettype wire
